// File: hw/rtl/wim_pkg.sv
package wim_pkg;

    localparam int BufDepth = 1024;
    localparam int AddrW = $clog2(BufDepth);
    localparam int PtrW = AddrW + 1;
    localparam int PosW = 32;
    localparam int ValW = 32;
    localparam int CntW = 11;
    localparam int OpW = 2;
    localparam int CfgIdxW = 2;
    localparam int QueueDepth = 2;

    localparam logic [OpW-1:0] OpPush = 2'd0;
    localparam logic [OpW-1:0] OpEval = 2'd1;
    localparam logic [OpW-1:0] OpClear = 2'd2;

    localparam logic [CfgIdxW-1:0] CfgInit = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgLength = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgStep = 2'd2;

    localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
    localparam logic [PosW-1:0] PosMax = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        t_cmd_push,
        t_cmd_eval,
        t_cmd_clear
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic [PosW-1:0] rec_start;
        logic [PosW-1:0] rec_end;
        logic signed [ValW-1:0] rec_value;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_DROP,
        S_RESCAN,
        S_EMIT
    } t_state;

    function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
                                                 input logic [PosW-1:0] b);
        logic [PosW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PosW] ? PosMax : s[PosW-1:0];
    endfunction

endpackage

// File: hw/rtl/wim_in_if.sv
interface wim_in_if;
    logic valid;
    logic ready;
    logic [wim_pkg::OpW-1:0] op;
    logic [wim_pkg::PosW-1:0] rec_start;
    logic [wim_pkg::PosW-1:0] rec_end;
    logic signed [wim_pkg::ValW-1:0] rec_value;
    modport source(output valid, op, rec_start, rec_end, rec_value, input ready);
    modport sink(input valid, op, rec_start, rec_end, rec_value, output ready);
endinterface

// File: hw/rtl/wim_out_if.sv
interface wim_out_if;
    logic valid;
    logic ready;
    logic [wim_pkg::PosW-1:0] win_begin;
    logic [wim_pkg::PosW-1:0] win_finish;
    logic signed [wim_pkg::ValW-1:0] win_minimum;
    logic [wim_pkg::CntW-1:0] win_count;
    logic is_empty;
    logic overflowed;
    modport source(output valid, win_begin, win_finish, win_minimum, win_count,
                   is_empty, overflowed, input ready);
    modport sink(input valid, win_begin, win_finish, win_minimum, win_count,
                 is_empty, overflowed, output ready);
endinterface

// File: hw/rtl/wim_front.sv
module wim_front (
    input  logic i_clk,
    input  logic i_rst_n,
    wim_in_if.sink in_ch,
    output logic o_q_valid,
    output wim_pkg::t_entry o_q_entry,
    input  logic i_q_pop
);

    wim_pkg::t_entry r_mem [wim_pkg::QueueDepth];
    logic r_wr;
    logic r_rd;
    logic [1:0] r_cnt;
    wim_pkg::t_entry w_entry;
    logic w_push;

    always_comb begin
        w_entry.rec_start = in_ch.rec_start;
        w_entry.rec_end = in_ch.rec_end;
        w_entry.rec_value = in_ch.rec_value;
        unique case (in_ch.op)
            wim_pkg::OpPush:  w_entry.cmd = wim_pkg::t_cmd_push;
            wim_pkg::OpEval:  w_entry.cmd = wim_pkg::t_cmd_eval;
            default:          w_entry.cmd = wim_pkg::t_cmd_clear;
        endcase
    end

    assign in_ch.ready = (r_cnt != 2'd2);
    assign w_push = in_ch.valid && in_ch.ready &&
                    (in_ch.op == wim_pkg::OpPush || in_ch.op == wim_pkg::OpEval ||
                     in_ch.op == wim_pkg::OpClear);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_entry;
        end
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule

// File: hw/rtl/wim_back.sv
module wim_back (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [wim_pkg::PosW-1:0] i_init,
    input  logic [wim_pkg::PosW-1:0] i_length,
    input  logic [wim_pkg::PosW-1:0] i_step,
    input  logic i_q_valid,
    input  wim_pkg::t_entry i_q_entry,
    output logic o_q_pop,
    wim_out_if.source out_ch
);

    localparam int AW = wim_pkg::AddrW;
    localparam int PW = wim_pkg::PtrW;

    logic [wim_pkg::PosW-1:0] r_starts [wim_pkg::BufDepth];
    logic [wim_pkg::PosW-1:0] r_ends [wim_pkg::BufDepth];
    logic signed [wim_pkg::ValW-1:0] r_values [wim_pkg::BufDepth];

    wim_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_push, r_take, r_drop, r_scan;
    logic signed [wim_pkg::ValW-1:0] r_min;
    logic [wim_pkg::PosW-1:0] r_wstart, r_wend;
    logic r_ovf, r_rescan, r_pend;
    logic [wim_pkg::PosW-1:0] r_rd_start, r_rd_end;
    logic signed [wim_pkg::ValW-1:0] r_rd_val;
    logic [AW-1:0] w_rd_addr;
    logic r_out_valid;
    logic [wim_pkg::PosW-1:0] r_o_begin, r_o_finish;
    logic signed [wim_pkg::ValW-1:0] r_o_min;
    logic [wim_pkg::CntW-1:0] r_o_cnt;
    logic r_o_ovf;
    logic w_pushing, w_full, w_out_free, w_adv;
    logic [PW-1:0] w_cnt;

    assign w_full = (r_push == PW'(wim_pkg::BufDepth));
    assign w_out_free = !r_out_valid || out_ch.ready;
    assign w_pushing = (r_state == wim_pkg::S_IDLE) && i_q_valid &&
                       (i_q_entry.cmd == wim_pkg::t_cmd_push) && !w_full;
    assign w_cnt = r_take - r_drop;
    assign w_adv = !r_pend &&
                   ((r_state == wim_pkg::S_TAKE && r_take < r_push &&
                     r_rd_start < r_wend) ||
                    (r_state == wim_pkg::S_DROP && r_drop < r_take &&
                     r_rd_end <= r_wstart) ||
                    (r_state == wim_pkg::S_RESCAN && r_scan < r_take));

    always_comb begin
        w_rd_addr = r_take[AW-1:0];
        unique case (n_state)
            wim_pkg::S_DROP:   w_rd_addr = r_drop[AW-1:0];
            wim_pkg::S_RESCAN: w_rd_addr = r_scan[AW-1:0];
            default:           w_rd_addr = r_take[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pushing) begin
            r_starts[r_push[AW-1:0]] <= i_q_entry.rec_start;
            r_ends[r_push[AW-1:0]] <= i_q_entry.rec_end;
            r_values[r_push[AW-1:0]] <= i_q_entry.rec_value;
        end
        r_rd_start <= r_starts[w_rd_addr];
        r_rd_end <= r_ends[w_rd_addr];
        r_rd_val <= r_values[w_rd_addr];
    end

    // r_pend marks the cycle in which read data is not yet valid for a fresh address.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wim_pkg::S_IDLE:
                if (i_q_valid && i_q_entry.cmd == wim_pkg::t_cmd_eval) begin
                    n_state = wim_pkg::S_TAKE;
                end
            wim_pkg::S_TAKE:
                if (!r_pend && !(r_take < r_push && r_rd_start < r_wend)) begin
                    n_state = wim_pkg::S_DROP;
                end
            wim_pkg::S_DROP:
                if (!r_pend && !(r_drop < r_take && r_rd_end <= r_wstart)) begin
                    n_state = r_rescan ? wim_pkg::S_RESCAN : wim_pkg::S_EMIT;
                end
            wim_pkg::S_RESCAN:
                if (!r_pend && !(r_scan < r_take)) begin
                    n_state = wim_pkg::S_EMIT;
                end
            wim_pkg::S_EMIT:
                if (w_out_free) begin
                    n_state = wim_pkg::S_IDLE;
                end
            default: n_state = wim_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        if (r_state == wim_pkg::S_IDLE && i_q_valid &&
            i_q_entry.cmd != wim_pkg::t_cmd_eval) begin
            o_q_pop = 1'b1;
        end
        if (r_state == wim_pkg::S_EMIT && w_out_free) begin
            o_q_pop = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wim_pkg::S_IDLE;
            r_push <= '0;
            r_take <= '0;
            r_drop <= '0;
            r_scan <= '0;
            r_min <= wim_pkg::ValMax;
            r_wstart <= '0;
            r_wend <= '0;
            r_ovf <= 1'b0;
            r_rescan <= 1'b0;
            r_pend <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend <= (n_state != r_state) || (r_state == wim_pkg::S_IDLE) || w_adv;
            if (r_state == wim_pkg::S_EMIT && w_out_free) r_out_valid <= 1'b1;
            else if (out_ch.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                wim_pkg::S_IDLE:
                    if (i_q_valid) begin
                        unique case (i_q_entry.cmd)
                            wim_pkg::t_cmd_push:
                                if (w_full) r_ovf <= 1'b1;
                                else r_push <= r_push + 1'b1;
                            wim_pkg::t_cmd_clear: begin
                                r_push <= '0;
                                r_take <= '0;
                                r_drop <= '0;
                                r_min <= wim_pkg::ValMax;
                                r_wstart <= i_init;
                                r_ovf <= 1'b0;
                            end
                            default: begin
                                r_wend <= wim_pkg::sat_add(r_wstart, i_length);
                                r_rescan <= 1'b0;
                            end
                        endcase
                    end
                wim_pkg::S_TAKE:
                    if (w_adv) begin
                        if (r_rd_val < r_min) r_min <= r_rd_val;
                        r_take <= r_take + 1'b1;
                    end
                wim_pkg::S_DROP:
                    if (w_adv) begin
                        if (r_rd_val == r_min) r_rescan <= 1'b1;
                        r_drop <= r_drop + 1'b1;
                    end else if (!r_pend && r_rescan) begin
                        r_min <= wim_pkg::ValMax;
                        r_scan <= r_drop;
                    end
                wim_pkg::S_RESCAN:
                    if (w_adv) begin
                        if (r_rd_val < r_min) r_min <= r_rd_val;
                        r_scan <= r_scan + 1'b1;
                    end
                wim_pkg::S_EMIT:
                    if (w_out_free) begin
                        r_o_begin <= r_wstart;
                        r_o_finish <= r_wend;
                        r_o_min <= r_min;
                        r_o_cnt <= wim_pkg::CntW'(w_cnt);
                        r_o_ovf <= r_ovf;
                        r_wstart <= wim_pkg::sat_add(r_wstart, i_step);
                    end
                default: ;
            endcase
        end
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.win_begin = r_o_begin;
    assign out_ch.win_finish = r_o_finish;
    assign out_ch.win_minimum = r_o_min;
    assign out_ch.win_count = r_o_cnt;
    assign out_ch.is_empty = (r_o_cnt == '0);
    assign out_ch.overflowed = r_o_ovf;

endmodule

// File: hw/rtl/windowed_interval_min_core.sv
// Push and clear beats are taken by the back end in its idle state after a two-entry queue.
// An evaluate takes records, drops records and, when a dropped record held the minimum,
// rescans the rest, walking the record memory through its single read port one entry
// per step. The result sits in an output register, so the next beat is taken meanwhile.
// Synchronous active-low reset clears pointers and flags and restores the register defaults.
module windowed_interval_min_core (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [wim_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    wim_in_if.sink in_ch,
    wim_out_if.source out_ch
);

    logic [wim_pkg::PosW-1:0] r_init, r_length, r_step;
    logic w_q_valid, w_q_pop;
    wim_pkg::t_entry w_q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
            r_length <= 32'd1000;
            r_step <= 32'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wim_pkg::CfgInit:   r_init <= i_cfg_data;
                wim_pkg::CfgLength: r_length <= i_cfg_data;
                wim_pkg::CfgStep:   r_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wim_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_q_valid(w_q_valid), .o_q_entry(w_q_entry), .i_q_pop(w_q_pop)
    );

    wim_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_init(r_init), .i_length(r_length), .i_step(r_step),
        .i_q_valid(w_q_valid), .i_q_entry(w_q_entry), .o_q_pop(w_q_pop),
        .out_ch(out_ch)
    );

endmodule

// File: tb/sv/windowed_interval_min_core_test.sv
module windowed_interval_min_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wim_pkg::*;

    localparam logic [OpW-1:0] OpUnused = 2'd3;

    typedef struct {
        logic [PosW-1:0] win_begin;
        logic [PosW-1:0] win_finish;
        logic signed [ValW-1:0] win_minimum;
        logic [CntW-1:0] win_count;
        logic is_empty;
        logic overflowed;
    } window_t;

    class interval_min_tracker;
        logic [PosW-1:0] starts[BufDepth];
        logic [PosW-1:0] ends[BufDepth];
        logic signed [ValW-1:0] values[BufDepth];
        int unsigned push_idx, take_idx, drop_idx;
        logic signed [ValW-1:0] least;
        logic [PosW-1:0] win_pos;
        logic ovf;
        logic [PosW-1:0] init_pos, length, step;
        window_t expected_windows[$];
        int unsigned errors;

        function new();
            init_pos = 0;
            length = 1000;
            step = 1000;
            restart();
            win_pos = 0;
            errors = 0;
        endfunction

        function void restart();
            push_idx = 0;
            take_idx = 0;
            drop_idx = 0;
            least = ValMax;
            win_pos = init_pos;
            ovf = 1'b0;
        endfunction

        function logic [PosW-1:0] add_sat(logic [PosW-1:0] a, logic [PosW-1:0] b);
            logic [PosW:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[PosW] ? PosMax : s[PosW-1:0];
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
            case (idx)
                CfgInit: init_pos = data;
                CfgLength: length = data;
                CfgStep: step = data;
                default: ;
            endcase
        endfunction

        function void note_beat(logic [OpW-1:0] op, logic [PosW-1:0] s,
                                logic [PosW-1:0] e, logic signed [ValW-1:0] v);
            logic [PosW-1:0] win_end;
            logic rescan;
            window_t w;
            rescan = 1'b0;
            case (op)
                OpPush: begin
                    if (push_idx >= BufDepth) begin
                        ovf = 1'b1;
                    end else begin
                        starts[push_idx] = s;
                        ends[push_idx] = e;
                        values[push_idx] = v;
                        push_idx++;
                    end
                end
                OpClear: restart();
                OpEval: begin
                    win_end = add_sat(win_pos, length);
                    while (take_idx < push_idx && starts[take_idx] < win_end) begin
                        if (values[take_idx] < least) least = values[take_idx];
                        take_idx++;
                    end
                    while (drop_idx < take_idx && ends[drop_idx] <= win_pos) begin
                        if (values[drop_idx] == least) rescan = 1'b1;
                        drop_idx++;
                    end
                    if (rescan) begin
                        least = ValMax;
                        for (int unsigned i = drop_idx; i < take_idx; i++)
                            if (values[i] < least) least = values[i];
                    end
                    w.win_begin = win_pos;
                    w.win_finish = win_end;
                    w.win_minimum = least;
                    w.win_count = CntW'(take_idx - drop_idx);
                    w.is_empty = (take_idx == drop_idx);
                    w.overflowed = ovf;
                    expected_windows.push_back(w);
                    win_pos = add_sat(win_pos, step);
                end
                default: ;
            endcase
        endfunction

        function void check_window(window_t got);
            window_t w;
            if (expected_windows.size() == 0) begin
                $error("unexpected window result, win_begin %0h", got.win_begin);
                errors++;
                return;
            end
            w = expected_windows.pop_front();
            if (got.win_begin !== w.win_begin) begin
                $error("win_begin: expected %0h, got %0h", w.win_begin, got.win_begin);
                errors++;
            end
            if (got.win_finish !== w.win_finish) begin
                $error("win_finish: expected %0h, got %0h", w.win_finish, got.win_finish);
                errors++;
            end
            if (got.win_minimum !== w.win_minimum) begin
                $error("win_minimum: expected %0d, got %0d", w.win_minimum,
                       got.win_minimum);
                errors++;
            end
            if (got.win_count !== w.win_count) begin
                $error("win_count: expected %0d, got %0d", w.win_count, got.win_count);
                errors++;
            end
            if (got.is_empty !== w.is_empty) begin
                $error("is_empty: expected %0b, got %0b", w.is_empty, got.is_empty);
                errors++;
            end
            if (got.overflowed !== w.overflowed) begin
                $error("overflowed: expected %0b, got %0b", w.overflowed, got.overflowed);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    wim_in_if in_ch();
    wim_out_if out_ch();

    windowed_interval_min_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    interval_min_tracker board = new();
    int unsigned burst_left = 0;
    logic long_hold_req = 1'b0;
    logic [PosW-1:0] rec_pos;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = OpPush;
        in_ch.rec_start = '0;
        in_ch.rec_end = '0;
        in_ch.rec_value = '0;
        out_ch.ready = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: checks each accepted window beat, then picks the next ready.
    always @(posedge i_clk) begin : receiver
        int unsigned mode_left, mode, hold_left;
        window_t got;
        if (out_ch.valid && out_ch.ready) begin
            got.win_begin = out_ch.win_begin;
            got.win_finish = out_ch.win_finish;
            got.win_minimum = out_ch.win_minimum;
            got.win_count = out_ch.win_count;
            got.is_empty = out_ch.is_empty;
            got.overflowed = out_ch.overflowed;
            board.check_window(got);
        end
        if (long_hold_req && hold_left == 0) begin
            hold_left = 3000;
            long_hold_req <= 1'b0;
        end
        if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 9) < 7);
                default: out_ch.ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    task automatic send_beat(logic [OpW-1:0] op, logic [PosW-1:0] s,
                             logic [PosW-1:0] e, logic signed [ValW-1:0] v);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.rec_start <= s;
        in_ch.rec_end <= e;
        in_ch.rec_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_beat(op, s, e, v);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (board.expected_windows.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] init_v, logic [31:0] len_v, logic [31:0] step_v);
        logic [31:0] vals[3];
        vals = '{init_v, len_v, step_v};
        foreach (vals[i]) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CfgIdxW'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            board.set_reg(CfgIdxW'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
        rec_pos = init_v;
    endtask

    function automatic logic [PosW-1:0] pos_add(logic [PosW-1:0] a, logic [PosW-1:0] b);
        return board.add_sat(a, b);
    endfunction

    task automatic push_ordered(int unsigned max_gap, int unsigned max_len);
        logic [PosW-1:0] s;
        rec_pos = pos_add(rec_pos, $urandom_range(0, max_gap));
        s = rec_pos;
        send_beat(OpPush, s, pos_add(s, $urandom_range(0, max_len)), $urandom);
    endtask

    task automatic run_sequence(int unsigned n, int unsigned max_gap, int unsigned max_len);
        int unsigned r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 60) push_ordered(max_gap, max_len);
            else if (r < 85) send_beat(OpEval, $urandom, $urandom, $urandom);
            else if (r < 90) send_beat(OpPush, $urandom, $urandom, $urandom);
            else if (r < 93) send_beat(OpUnused, $urandom, $urandom, $urandom);
            else if (r < 95) begin
                send_beat(OpClear, $urandom, $urandom, $urandom);
                rec_pos = board.init_pos;
            end else begin
                send_beat(OpPush, rec_pos - $urandom_range(0, 2000), $urandom, $urandom);
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] len_v, step_v;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(OpPush, 32'd0, 32'd500, -32'sd1);
        send_beat(OpPush, 32'd10, 32'd2000, ValMax);
        send_beat(OpPush, 32'd999, 32'd1000, 32'sh8000_0000);
        send_beat(OpEval, '0, '0, '0);
        send_beat(OpEval, '1, '1, '1);
        send_beat(OpEval, '0, '0, '0);
        send_beat(OpUnused, '1, '1, '1);
        send_beat(OpPush, 32'd3000, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_beat(OpPush, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -32'sd1);
        send_beat(OpEval, '0, '0, '0);
        send_beat(OpClear, '0, '0, '0);
        send_beat(OpEval, '0, '0, '0);
        drain();

        write_regs(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OpClear, '0, '0, '0);
        send_beat(OpPush, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'sd5);
        send_beat(OpPush, 32'hFFFF_FFFE, 32'hFFFF_FFFF, -32'sd7);
        send_beat(OpEval, '0, '0, '0);
        send_beat(OpEval, '0, '0, '0);
        send_beat(OpEval, '0, '0, '0);
        drain();

        write_regs(32'd0, 32'd1, 32'd1);
        send_beat(OpClear, '0, '0, '0);
        send_beat(OpPush, 32'd0, 32'd1, 32'sd9);
        send_beat(OpPush, 32'd1, 32'd2, 32'sd9);
        send_beat(OpEval, '0, '0, '0);
        send_beat(OpEval, '0, '0, '0);
        send_beat(OpEval, '0, '0, '0);
        drain();

        // Fill the buffer past its depth, then walk windows across it.
        write_regs(32'd0, 32'd1000, 32'd1000);
        send_beat(OpClear, '0, '0, '0);
        long_hold_req <= 1'b1;
        repeat (BufDepth + 6) push_ordered(40, 3000);
        repeat (12) send_beat(OpEval, '0, '0, '0);
        drain();

        repeat (6) begin
            len_v = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 5000);
            step_v = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 5000);
            write_regs(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 10000),
                       len_v, step_v);
            send_beat(OpClear, '0, '0, '0);
            run_sequence(150, (step_v > 4000) ? 4000 : step_v / 2 + 1,
                         (len_v > 6000) ? 6000 : 2 * len_v);
            drain();
        end

        if (board.errors == 0 && board.expected_windows.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/wim_pkg.sv
hw/rtl/wim_in_if.sv
hw/rtl/wim_out_if.sv
hw/rtl/wim_front.sv
hw/rtl/wim_back.sv
hw/rtl/windowed_interval_min_core.sv
tb/sv/windowed_interval_min_core_test.sv
